// ----- sv/bca_pkg.sv -----
// bca_pkg: shared constants for the bitmap chunk allocator
// status codes, register indexes, field widths and parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bca_pkg;
    localparam int WORD_BITS_DEF  = 64;
    localparam int MAX_CHUNKS_DEF = 1024;

    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 3;
    localparam int STRIDE_W = 17;
    localparam int LIMIT_W  = COUNT_W + STRIDE_W;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISALIGNED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALIGN_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd3;

    localparam logic [SIZE_W-1:0]  CHUNK_BYTES_RST = 16'd64;
    localparam logic [SIZE_W-1:0]  ALIGN_BYTES_RST = 16'd8;
    localparam logic [COUNT_W-1:0] CHUNKS_RST      = 11'd1024;
    localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd0;

    localparam int DIV_N = 32;
    localparam int DIV_D = STRIDE_W;

    typedef struct packed {
        logic                 start;
        logic [DIV_N-1:0]     dividend;
        logic [DIV_D-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_N-1:0]     quotient;
        logic [DIV_D-1:0]     remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

// ----- sv/bca_ram.sv -----
// bca_ram: generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module bca_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- sv/bca_div.sv -----
// bca_div: restoring divider, one quotient bit per cycle
// depends on bca_pkg
`timescale 1ns / 1ps
`default_nettype none
module bca_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bca_pkg::div_req_t req,
    output bca_pkg::div_rsp_t   rsp
);
    import bca_pkg::*;

    localparam int CNT_W = $clog2(DIV_N + 1);

    logic [DIV_N-1:0] quo_reg, quo_next;
    logic [DIV_D-1:0] rem_reg, rem_next;
    logic [DIV_D-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DIV_D:0]   trial;
    logic             ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIV_N-1]};
        ge        = trial >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = CNT_W'(DIV_N);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[DIV_N-2:0], ge};
            rem_next = ge ? DIV_D'(trial - {1'b0, dvs_reg}) : DIV_D'(trial);
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

// ----- sv/bitmap_chunk_allocator_core.sv -----
// bitmap_chunk_allocator_core: fixed-size chunk pool with an occupancy bitmap in ram
// depends on bca_pkg, bca_ram, bca_div
//
// usage: requests arrive as beats on the s_ channel (tuser = op, 0 allocate, 1 free),
// one result beat per request leaves on the m_ channel. configuration is written
// through cfg_we / cfg_index / cfg_data; the user must write it only while no request
// is in flight, as the block itself does not enforce it. one request is worked on at
// a time. every request first computes the stride with the serial 32-step divider.
// an allocate then scans bitmap words from the search pointer, reading (S_ARD) and
// evaluating (S_AEV) each, up to all NUM_WORDS words, then forms the address in
// S_AMUL and S_AADD. a free runs the divider once more (offset / stride), splits
// the index into word and bit, and does a read-modify-write of one word. the next
// request is accepted in the cycle after the result is formed. the result sits in
// an output register; a new request is taken while it waits, and the block holds
// its last step until the receiver takes the previous beat. reset clears all
// control state and marks every bitmap word as never written, so every chunk reads
// as free; the search pointer starts at word 0.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_chunk_allocator_core #(
    parameter int WORD_BITS  = bca_pkg::WORD_BITS_DEF,
    parameter int MAX_CHUNKS = bca_pkg::MAX_CHUNKS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] request_size, [47:16] free_address
    input  wire logic [bca_pkg::IN_DATA_W-1:0]   s_tdata,
    // [0] op
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [2:0] status, [34:3] chunk_address, [44:35] chunk_index, rest zero
    output logic [bca_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  wire logic                            cfg_we,
    input  wire logic [bca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bca_pkg::ADDR_W-1:0]      cfg_data
);
    import bca_pkg::*;

    localparam int NUM_WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WW = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int KW = $clog2(NUM_WORDS + 1);
    localparam int BW = $clog2(WORD_BITS);
    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int PW = IW + STRIDE_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SDIV  = 4'd1;
    localparam logic [3:0] S_SMUL  = 4'd2;
    localparam logic [3:0] S_LIM   = 4'd3;
    localparam logic [3:0] S_ARD   = 4'd4;
    localparam logic [3:0] S_AEV   = 4'd5;
    localparam logic [3:0] S_AMUL  = 4'd6;
    localparam logic [3:0] S_AADD  = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;
    localparam logic [3:0] S_FDIV  = 4'd9;
    localparam logic [3:0] S_FRD   = 4'd11;
    localparam logic [3:0] S_FWR   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    // configuration
    logic [SIZE_W-1:0]  chunk_bytes_reg, align_bytes_reg;
    logic [COUNT_W-1:0] chunks_reg;
    logic [ADDR_W-1:0]  pool_base_reg;

    // control
    logic [3:0]           state_reg, state_next;
    logic [WW-1:0]        search_reg, search_next;
    logic [NUM_WORDS-1:0] entry_ok_reg, entry_ok_next;
    logic                 m_valid_reg, m_valid_next;
    logic [KW-1:0]        k_reg, k_next;

    // per-request payload
    logic                 op_reg, op_next;
    logic [SIZE_W-1:0]    req_reg, req_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [STRIDE_W-1:0]  st_reg, st_next;
    logic [LIMIT_W-1:0]   lim_reg, lim_next;
    logic [ADDR_W-1:0]    off_reg, off_next;
    logic [WW-1:0]        word_reg, word_next;
    logic [BW-1:0]        bit_reg, bit_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [ADDR_W-1:0]    caddr_reg, caddr_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    div_req_t             div_req_reg, div_req_next;
    div_rsp_t             div_rsp;

    logic                 ram_we;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata, word_q;

    logic [SIZE_W-1:0]    c_eff, a_eff;
    logic [COUNT_W-1:0]   cnt_eff;
    logic [31:0]          wbase, shamt;
    logic [WORD_BITS-1:0] vmask, free_bits;
    logic [BW-1:0]        low_bit;

    bca_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (word_reg),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    bca_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        c_eff   = (chunk_bytes_reg == '0) ? SIZE_W'(1) : chunk_bytes_reg;
        a_eff   = (align_bytes_reg == '0) ? SIZE_W'(1) : align_bytes_reg;
        cnt_eff = (32'(chunks_reg) > 32'(MAX_CHUNKS)) ? COUNT_W'(MAX_CHUNKS) : chunks_reg;

        // chunks at or above the count read as used
        wbase = 32'(word_reg) * 32'(WORD_BITS);
        shamt = 32'(cnt_eff) - wbase;
        if (32'(cnt_eff) >= wbase + 32'(WORD_BITS))
            vmask = '1;
        else if (32'(cnt_eff) <= wbase)
            vmask = '0;
        else
            vmask = ~({WORD_BITS{1'b1}} << shamt);

        word_q    = entry_ok_reg[word_reg] ? ram_rdata : '0;
        free_bits = vmask & ~word_q;
        low_bit   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_bits[i])
                low_bit = BW'(i);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        search_next   = search_reg;
        entry_ok_next = entry_ok_reg;
        m_valid_next  = m_valid_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        st_next       = st_reg;
        lim_next      = lim_reg;
        off_next      = off_reg;
        word_next     = word_reg;
        bit_next      = bit_reg;
        idx_next      = idx_reg;
        prod_next     = prod_reg;
        status_next   = status_reg;
        caddr_next    = caddr_reg;
        m_data_next   = m_data_reg;
        div_req_next  = div_req_reg;
        div_req_next.start = 1'b0;
        ram_we        = 1'b0;
        ram_wdata     = word_q | (WORD_BITS'(1) << low_bit);
        s_tready      = (state_reg == S_IDLE);

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    req_next    = s_tdata[15:0];
                    addr_next   = s_tdata[47:16];
                    status_next = STATUS_OK;
                    caddr_next  = '0;
                    idx_next    = '0;
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_N'(17'(c_eff) + 17'(a_eff) - 17'd1);
                    div_req_next.divisor  = DIV_D'(a_eff);
                    state_next  = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_rsp.done)
                    state_next = S_SMUL;
            end
            S_SMUL:
            begin
                st_next    = STRIDE_W'(div_rsp.quotient[STRIDE_W-1:0] * STRIDE_W'(a_eff));
                state_next = S_LIM;
            end
            S_LIM:
            begin
                lim_next = LIMIT_W'(cnt_eff) * LIMIT_W'(st_reg);
                off_next = addr_reg - pool_base_reg;
                if (op_reg)
                    state_next = S_FCHK;
                else if (32'(req_reg) > 32'(c_eff))
                begin
                    status_next = STATUS_TOO_LARGE;
                    state_next  = S_DONE;
                end
                else
                begin
                    word_next  = search_reg;
                    k_next     = '0;
                    state_next = S_ARD;
                end
            end
            S_ARD:
            begin
                state_next = S_AEV;
            end
            S_AEV:
            begin
                if (free_bits != '0)
                begin
                    ram_we        = 1'b1;
                    entry_ok_next[word_reg] = 1'b1;
                    search_next   = word_reg;
                    idx_next      = IW'(wbase + 32'(low_bit));
                    state_next    = S_AMUL;
                end
                else if (k_reg == KW'(NUM_WORDS - 1))
                begin
                    status_next = STATUS_FULL;
                    search_next = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    word_next  = (word_reg == WW'(NUM_WORDS - 1)) ? '0 : word_reg + 1'b1;
                    state_next = S_ARD;
                end
            end
            S_AMUL:
            begin
                prod_next  = PW'(idx_reg) * PW'(st_reg);
                state_next = S_AADD;
            end
            S_AADD:
            begin
                caddr_next = pool_base_reg + 32'(prod_reg);
                state_next = S_DONE;
            end
            S_FCHK:
            begin
                if (addr_reg < pool_base_reg || off_reg >= 32'(lim_reg))
                begin
                    status_next = STATUS_OUTSIDE;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = off_reg;
                    div_req_next.divisor  = st_reg;
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder != '0)
                    begin
                        status_next = STATUS_MISALIGNED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        // word and bit are the upper and lower parts of the index
                        idx_next   = IW'(div_rsp.quotient);
                        word_next  = WW'(div_rsp.quotient >> BW);
                        bit_next   = div_rsp.quotient[BW-1:0];
                        state_next = S_FRD;
                    end
                end
            end
            S_FRD:
            begin
                state_next = S_FWR;
            end
            S_FWR:
            begin
                ram_we    = 1'b1;
                ram_wdata = word_q & ~(WORD_BITS'(1) << bit_reg);
                entry_ok_next[word_reg] = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_DATA_W'({INDEX_W'(idx_reg), caddr_reg, status_reg});
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            search_reg       <= '0;
            entry_ok_reg     <= '0;
            m_valid_reg      <= 1'b0;
            k_reg            <= '0;
            div_req_reg      <= '0;
            chunk_bytes_reg  <= CHUNK_BYTES_RST;
            align_bytes_reg  <= ALIGN_BYTES_RST;
            chunks_reg       <= CHUNKS_RST;
            pool_base_reg    <= POOL_BASE_RST;
        end
        else
        begin
            state_reg        <= state_next;
            search_reg       <= search_next;
            entry_ok_reg     <= entry_ok_next;
            m_valid_reg      <= m_valid_next;
            k_reg            <= k_next;
            div_req_reg      <= div_req_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CHUNK_BYTES: chunk_bytes_reg <= cfg_data[SIZE_W-1:0];
                    REG_ALIGN_BYTES: align_bytes_reg <= cfg_data[SIZE_W-1:0];
                    REG_CHUNKS:      chunks_reg      <= cfg_data[COUNT_W-1:0];
                    REG_POOL_BASE:   pool_base_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        st_reg      <= st_next;
        lim_reg     <= lim_next;
        off_reg     <= off_next;
        word_reg    <= word_next;
        bit_reg     <= bit_next;
        idx_reg     <= idx_next;
        prod_reg    <= prod_next;
        status_reg  <= status_next;
        caddr_reg   <= caddr_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
endmodule
`default_nettype wire
